>>> rtl/core/afrf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio frame ring FIFO.
// No dependencies; imported by every module of the block.
package afrf_pkg;

  localparam int FRAMES    = 4096;
  localparam int CHANNELS  = 8;
  localparam int SAMPLE_W  = 32;
  localparam int POS_W     = $clog2(FRAMES);
  localparam int CAP_W     = POS_W + 1;
  localparam int NCH_W     = 4;
  localparam int FRAME_W   = CHANNELS * SAMPLE_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CAP_W;
  localparam int OP_W      = 2;

  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(FRAMES);
  localparam logic [NCH_W-1:0] NCH_MAX   = NCH_W'(CHANNELS);
  localparam logic [NCH_W-1:0] NCH_RESET = NCH_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'b1;

  // Frame store access issued by the ring control
  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    logic             re;
    logic [POS_W-1:0] raddr;
  } ram_req_t;

  // Per-beat result information that travels beside the store read
  typedef struct packed {
    logic                done;
    logic [CHANNELS-1:0] lane_en;
    logic [POS_W-1:0]    fill;
    logic [POS_W-1:0]    free;
  } res_meta_t;

endpackage

>>> rtl/core/afrf_ram.sv
`timescale 1ns / 1ps
// Frame store: one word per frame slot holding all channel samples.
// Depends on afrf_pkg; one write and one registered read per cycle.
module afrf_ram (
  input  logic                      clk,
  input  afrf_pkg::ram_req_t        req,
  input  logic [afrf_pkg::FRAME_W-1:0] wdata,
  output logic [afrf_pkg::FRAME_W-1:0] rdata_r
);
  import afrf_pkg::*;

  logic [FRAME_W-1:0] mem [FRAMES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
  end

  // read data holds when no read is issued, so a stalled result keeps it
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/core/afrf_ctrl.sv
`timescale 1ns / 1ps
// Ring control: configuration registers, positions and fill count.
// Depends on afrf_pkg; drives the frame store and the result metadata.
module afrf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           go,
  input  afrf_pkg::op_t                  op,
  output afrf_pkg::ram_req_t             req,
  output afrf_pkg::res_meta_t            meta
);
  import afrf_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [NCH_W-1:0] nch_r, nch_nxt;
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0] rp_r, rp_nxt;
  logic [POS_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0] wp_inc, rp_inc;
  logic [CAP_W-1:0] cap_m1;
  logic             full, empty, show;
  logic [3:0]       cfg_nch;

  assign cap_m1 = cap_r - CAP_W'(1);
  assign full   = ({1'b0, fill_r} == cap_m1);
  assign empty  = (fill_r == '0);
  assign wp_inc = ((CAP_W'(wp_r) + CAP_W'(1)) == cap_r) ? '0 : wp_r + POS_W'(1);
  assign rp_inc = ((CAP_W'(rp_r) + CAP_W'(1)) == cap_r) ? '0 : rp_r + POS_W'(1);
  assign cfg_nch = cfg_wdata[NCH_W-1:0];

  // clamp register writes into range so the datapath never sees odd values
  always_comb begin
    cap_nxt = cap_r;
    nch_nxt = nch_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CAPACITY: begin
          if (cfg_wdata < CAP_MIN) cap_nxt = CAP_MIN;
          else if (cfg_wdata > CAP_MAX) cap_nxt = CAP_MAX;
          else cap_nxt = cfg_wdata;
        end
        CFG_CHANNELS: begin
          if (cfg_nch == '0) nch_nxt = NCH_W'(1);
          else if (cfg_nch > NCH_MAX) nch_nxt = NCH_MAX;
          else nch_nxt = cfg_nch;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    fill_nxt  = fill_r;
    req       = '0;
    req.waddr = wp_r;
    req.raddr = rp_r;
    meta.done = 1'b0;
    show      = 1'b0;
    if (cfg_wr_en) begin
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
    end else if (go) begin
      case (op)
        OP_WRITE: begin
          if (!full) begin
            req.we    = 1'b1;
            wp_nxt    = wp_inc;
            fill_nxt  = fill_r + POS_W'(1);
            meta.done = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          if (!empty) begin
            req.re    = 1'b1;
            show      = 1'b1;
            meta.done = 1'b1;
            if (op == OP_READ) begin
              rp_nxt   = rp_inc;
              fill_nxt = fill_r - POS_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          wp_nxt    = '0;
          rp_nxt    = '0;
          fill_nxt  = '0;
          meta.done = 1'b1;
        end
        default: ;
      endcase
    end
    meta.fill = fill_nxt;
    meta.free = POS_W'(cap_m1 - CAP_W'(fill_nxt));
    for (int c = 0; c < CHANNELS; c++) begin
      meta.lane_en[c] = show && (NCH_W'(c) < nch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_MAX;
      nch_r  <= NCH_RESET;
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      cap_r  <= cap_nxt;
      nch_r  <= nch_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(fill_r) < cap_r)
    else $error("fill count reaches capacity");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CAP_W'(wp_r) < cap_r) && (CAP_W'(rp_r) < cap_r))
    else $error("position outside ring");

  a_pos_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ((CAP_W'(rp_r) + CAP_W'(fill_r)) == CAP_W'(wp_r)) ||
    ((CAP_W'(rp_r) + CAP_W'(fill_r)) == (CAP_W'(wp_r) + cap_r)))
    else $error("positions disagree with fill count");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    (req.we && req.re) |-> 1'b0)
    else $error("write and read issued together");

endmodule

>>> rtl/core/audio_frame_ring_fifo.sv
`timescale 1ns / 1ps
// Top level of the audio frame ring FIFO: handshakes and result register.
// Depends on afrf_pkg, afrf_ctrl and afrf_ram.
//
//  port group | dir | tdata                          | tuser
//  -----------+-----+--------------------------------+-----------------
//  in_        | in  | in_sample_0..7 (8 x 32 bits)   | operation (2)
//  out_       | out | out_sample_0..7, fill, free    | done_res (1)
//  cfg_       | in  | write enable, index, data      | -
//
// One beat per cycle while in_tready is high: an item is taken in the cycle it
// arrives, its store access goes out at once and the result appears in the next cycle from the
// store's read register. The single result register sets the rate: a new
// beat is taken while the held result is being taken or when none is held.
// A stalled result holds its beat and the store's read register.
// Reset (synchronous, rst_n low) empties the ring, capacity 4096 frames and
// two channels; the store itself is not cleared. Any register write also
// empties the ring.
module audio_frame_ring_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::CFG_W-1:0]     cfg_wdata,
  // input frames
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [255:0]                   in_tdata,  // in_sample_0 .. in_sample_7
  input  logic [1:0]                     in_tuser,  // operation
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [279:0]                   out_tdata, // out_sample_0..7, fill_frames, free_frames
  output logic                           out_tuser  // done_res
);
  import afrf_pkg::*;

  ram_req_t           req;
  res_meta_t          meta;
  res_meta_t          meta_r;
  logic [FRAME_W-1:0] rdata_r;
  logic               go;
  logic               vld_r, vld_nxt;
  logic [FRAME_W-1:0] samples;

  // take a beat when the result register is empty or being emptied
  assign in_tready = !vld_r || out_tready;
  assign go        = in_tvalid && in_tready;

  afrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .op        (op_t'(in_tuser)),
    .req       (req),
    .meta      (meta)
  );

  afrf_ram u_ram (
    .clk     (clk),
    .req     (req),
    .wdata   (in_tdata),
    .rdata_r (rdata_r)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (go) vld_nxt = 1'b1;
    else if (out_tready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // metadata needs no reset: it is only looked at while vld_r is set
  always_ff @(posedge clk) begin
    if (go) begin
      meta_r <= meta;
    end
  end

  // zero lanes above the channel count, and all lanes when nothing was read
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      samples[c*SAMPLE_W +: SAMPLE_W] =
        rdata_r[c*SAMPLE_W +: SAMPLE_W] & {SAMPLE_W{meta_r.lane_en[c]}};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {meta_r.free, meta_r.fill, samples};
  assign out_tuser  = meta_r.done;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for audio_frame_ring_fifo: directed and random frame traffic
// against a cycle-free model of the ring. Depends on afrf_pkg and the block's RTL.
module testbench;
  import afrf_pkg::*;

  localparam int CYCLE_LIMIT = 60000;
  localparam int PRINT_LIMIT = 200;
  localparam int DEEP_SLOTS  = 256;

  // Result beat as it leaves the block: {out_tuser, out_tdata}
  typedef struct packed {
    logic              done;
    logic [POS_W-1:0]  free;
    logic [POS_W-1:0]  fill;
    logic [FRAME_W-1:0] samples;
  } ring_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [255:0]         in_tdata   = '0;  // in_sample_0 .. in_sample_7
  logic [1:0]           in_tuser   = '0;  // operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [279:0]         out_tdata;        // out_sample_0..7, fill_frames, free_frames
  logic                 out_tuser;        // done_res

  // Idling controls shared by the sender, the sink and the tests
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int sink_hold = 0;

  int mismatches = 0;
  int cycles     = 0;

  // Shadow of the ring: frame store, positions and both registers
  logic [SAMPLE_W-1:0] ring_store [FRAMES][CHANNELS];
  int unsigned         ring_wr;
  int unsigned         ring_rd;
  logic [CFG_W-1:0]    ring_capacity;
  logic [NCH_W-1:0]    ring_channels;

  ring_result_t expected_results[$];

  audio_frame_ring_fifo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run well past the slowest legal finish
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------

  // Clamp the capacity register to the usable range of ring sizes
  function automatic int unsigned ring_slots();
    if (ring_capacity < CAP_MIN) return 2;
    if (ring_capacity > CAP_MAX) return FRAMES;
    return 32'(ring_capacity);
  endfunction

  // Clamp the channel register: zero acts as one, anything above eight as eight
  function automatic int unsigned ring_lanes();
    if (ring_channels == 0) return 1;
    if (ring_channels > NCH_MAX) return CHANNELS;
    return 32'(ring_channels);
  endfunction

  // Apply one operation to the shadow ring and return the beat it should produce
  function automatic ring_result_t ring_step(op_t op, logic [FRAME_W-1:0] frame);
    ring_result_t r;
    int unsigned  slots;
    int unsigned  lanes;
    int unsigned  fill;
    r     = '0;
    slots = ring_slots();
    lanes = ring_lanes();
    ring_wr = ring_wr % slots;
    ring_rd = ring_rd % slots;
    fill    = (ring_wr + slots - ring_rd) % slots;
    case (op)
      OP_WRITE: begin
        // one slot stays empty, so the ring is full at slots - 1 frames
        if (fill < slots - 1) begin
          for (int c = 0; c < lanes; c++) ring_store[ring_wr][c] = frame[c*SAMPLE_W +: SAMPLE_W];
          ring_wr = (ring_wr + 1) % slots;
          r.done  = 1'b1;
        end
      end
      OP_READ, OP_PEEK: begin
        // underrun leaves done low and the samples silent
        if (fill > 0) begin
          for (int c = 0; c < lanes; c++) r.samples[c*SAMPLE_W +: SAMPLE_W] = ring_store[ring_rd][c];
          if (op == OP_READ) ring_rd = (ring_rd + 1) % slots;
          r.done = 1'b1;
        end
      end
      default: begin
        ring_wr = 0;
        ring_rd = 0;
        r.done  = 1'b1;
      end
    endcase
    fill   = (ring_wr + slots - ring_rd) % slots;
    r.fill = POS_W'(fill);
    r.free = POS_W'(slots - 1 - fill);
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: track register writes and accepted frames, then check results.
  // Predict before checking so that a same-edge result still finds its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    ring_result_t want;
    ring_result_t got;
    if (!rst_n) begin
      ring_wr       = 0;
      ring_rd       = 0;
      ring_capacity = CAP_MAX;
      ring_channels = NCH_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_CAPACITY) ring_capacity = cfg_wdata;
        else ring_channels = cfg_wdata[NCH_W-1:0];
        // any register write rebuilds the ring empty
        ring_wr = 0;
        ring_rd = 0;
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(ring_step(op_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT)
            $display("%0t: result beat with nothing expected, expected none, actual %h",
                     $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("done_res", 32'(want.done), 32'(got.done));
          for (int c = 0; c < CHANNELS; c++)
            check_field($sformatf("out_sample_%0d", c), want.samples[c*SAMPLE_W +: SAMPLE_W],
                        got.samples[c*SAMPLE_W +: SAMPLE_W]);
          check_field("fill_frames", 32'(want.fill), 32'(got.fill));
          check_field("free_frames", 32'(want.free), 32'(got.free));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: stall at random before each beat while sink_idle is set, or hold off while sink_hold
  // counts down when a test asks for back-pressure. Ready is only changed at falling edges.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      while (stall > 0 || sink_hold > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        if (sink_hold > 0) sink_hold--;
        else stall--;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat after an optional gap and hold it until the block takes it
  task automatic send_frame(op_t op, logic [FRAME_W-1:0] frame);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= frame;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every expected beat, then allow for the result stage
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly random samples, with the all-zero and all-one extremes now and then
  function automatic logic [FRAME_W-1:0] random_frame();
    logic [FRAME_W-1:0] f;
    case ($urandom_range(0, 7))
      0:       f = '0;
      1:       f = '1;
      default: for (int c = 0; c < CHANNELS; c++) f[c*SAMPLE_W +: SAMPLE_W] = $urandom;
    endcase
    return f;
  endfunction

  // Weighted towards writes and reads so that small rings wrap, fill and drain
  function automatic op_t random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return OP_WRITE;
    if (pick < 75) return OP_READ;
    if (pick < 93) return OP_PEEK;
    return OP_CLEAR;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (4096 frames, two channels): underrun, unused lanes, clear
  task automatic test_reset_defaults();
    send_frame(OP_PEEK, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_WRITE, '1);
    send_frame(OP_WRITE, '0);
    send_frame(OP_WRITE, {8{32'hA5A5_5A5A}});
    send_frame(OP_PEEK, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_CLEAR, random_frame());
    send_frame(OP_READ, random_frame());
  endtask

  // Smallest rings: full drop, wrap, clamping of capacity, and register writes
  // emptying the ring
  task automatic test_tiny_ring();
    write_register(CFG_CHANNELS, CFG_W'(CHANNELS));
    write_register(CFG_CAPACITY, '0);
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_PEEK, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_READ, random_frame());
    write_register(CFG_CAPACITY, CFG_W'(1));
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_READ, random_frame());
    write_register(CFG_CAPACITY, CFG_W'(3));
    repeat (3) send_frame(OP_WRITE, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_WRITE, random_frame());
    repeat (3) send_frame(OP_READ, random_frame());
    send_frame(OP_WRITE, random_frame());
    write_register(CFG_CHANNELS, CFG_W'(CHANNELS));
    send_frame(OP_READ, random_frame());
  endtask

  // Channel counts across and beyond the legal range, and an oversize capacity
  task automatic test_channel_limits();
    int counts[6] = '{0, 1, 9, 15, 8, 4};
    foreach (counts[i]) begin
      write_register(CFG_CHANNELS, CFG_W'(counts[i]));
      send_frame(OP_WRITE, '1);
      send_frame(OP_PEEK, random_frame());
    end
    write_register(CFG_CAPACITY, '1);
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_READ, random_frame());
  endtask

  // A 256-frame ring filled to the brim, write position wrapped past the top slot
  task automatic test_deep_ring();
    write_register(CFG_CAPACITY, CFG_W'(DEEP_SLOTS));
    write_register(CFG_CHANNELS, CFG_W'(CHANNELS));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (DEEP_SLOTS) send_frame(OP_WRITE, random_frame());
    send_frame(OP_READ, random_frame());
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_WRITE, random_frame());
    send_frame(OP_PEEK, random_frame());
    repeat (3) send_frame(OP_READ, random_frame());
    send_frame(OP_CLEAR, random_frame());
    send_frame(OP_READ, random_frame());
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Hold the sink off for a long stretch while frames keep coming, so the
  // result stage fills and in_tready has to drop
  task automatic test_backpressure();
    write_register(CFG_CAPACITY, CFG_W'(6));
    write_register(CFG_CHANNELS, CFG_W'(3));
    src_idle  = 1'b0;
    sink_hold = 80;
    repeat (40) send_frame(random_op(), random_frame());
    src_idle = 1'b1;
  endtask

  // Random settings per phase, mostly small rings so that full and empty come often
  task automatic test_random_traffic();
    int pick;
    for (int phase = 0; phase < 6; phase++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) write_register(CFG_CAPACITY, CFG_W'($urandom_range(2, 12)));
      else if (pick < 16) write_register(CFG_CAPACITY, CFG_W'($urandom_range(0, 1)));
      else if (pick < 17) write_register(CFG_CAPACITY, CFG_W'($urandom_range(4097, 8191)));
      else write_register(CFG_CAPACITY, CFG_W'($urandom_range(13, FRAMES)));
      write_register(CFG_CHANNELS, CFG_W'($urandom_range(0, 15)));
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (40) send_frame(random_op(), random_frame());
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run each test in turn, drain and report
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_tiny_ring();
    test_channel_limits();
    test_deep_ring();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
